// ----- hw/rtl/cheb2d_pkg.sv -----
package cheb2d_pkg;

	// field widths
	localparam int COEFF_W = 32;
	localparam int PT_W    = 18;
	localparam int IDX_W   = 8;
	localparam int CFG_W   = 4;
	localparam int OUT_W   = 48;

	localparam int MAX_ORDER_DEF = 15;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic signed [PT_W-1:0]    point_t;
	typedef logic signed [OUT_W-1:0]   result_t;
	typedef logic [CFG_W-1:0]          order_t;
	typedef logic [IDX_W-1:0]          index_t;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// register indexes
	localparam logic CFG_ORDER_X = 1'b0;
	localparam logic CFG_ORDER_Y = 1'b1;

	localparam order_t ORDER_RST = 4'd10;

	// Q1.16 unit
	localparam point_t ONE_Q16 = 18'sd65536;

	localparam result_t OUT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam result_t OUT_MIN = 48'sh8000_0000_0000;

endpackage

// ----- hw/rtl/cheb2d_coeff_ram.sv -----
module cheb2d_coeff_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  cheb2d_pkg::coeff_t   wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output cheb2d_pkg::coeff_t   rdata
);
	import cheb2d_pkg::*;

	coeff_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/chebyshev_2d_series_eval.sv -----
// Channel     Ports                                              Handshake
// ----------  -------------------------------------------------  ---------------------------
// command in  operation coeff_index coeff_value x_point y_point  start high, busy low
// result out  series_value                                       done strobe, one cycle
// config      cfg_index cfg_data                                 cfg_we high, taken at once
//
// A load transaction leaves busy low.
// An evaluation holds busy until done; its length grows with the clipped x and y orders,
// and the one multiplier and the single coefficient store read port, one coefficient
// per cycle, set it.
// arst_n clears the sequencer and done and sets both order registers to 10; the store is not cleared.
// The result appears on series_value with done and holds until the next result; the receiver cannot stall.
module chebyshev_2d_series_eval #(
	parameter int MAX_ORDER = cheb2d_pkg::MAX_ORDER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  cheb2d_pkg::index_t    coeff_index,
	input  cheb2d_pkg::coeff_t    coeff_value,
	input  cheb2d_pkg::point_t    x_point,
	input  cheb2d_pkg::point_t    y_point,
	output cheb2d_pkg::result_t   series_value,
	output logic                  done,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  cheb2d_pkg::order_t    cfg_data
);
	import cheb2d_pkg::*;

	localparam int STRIDE  = MAX_ORDER + 1;
	localparam int DEPTH   = STRIDE * STRIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ORD_W   = $clog2(STRIDE);
	localparam int K_W     = ORD_W + 1;
	// inner sum: 32x18 products, up to 2^ORD_W of them
	localparam int AM_W    = COEFF_W + PT_W + ORD_W;
	localparam int AMR_W   = AM_W + 1 - 16;
	localparam int MA_W    = AMR_W;
	localparam int PROD_W  = MA_W + PT_W;
	localparam int ZW      = PROD_W + ORD_W;
	localparam int ZR_W    = ZW + 1 - 16;
	localparam int EXT_W   = (ZR_W > OUT_W) ? ZR_W : OUT_W + 1;

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TX     = 4'd1;  // build T_k(x)
	localparam logic [3:0] S_TY     = 4'd2;  // build T_k(y)
	localparam logic [3:0] S_INNER  = 4'd3;  // stream one column of coefficients
	localparam logic [3:0] S_WAIT   = 4'd4;  // drain the MAC pipe, round a_m
	localparam logic [3:0] S_OUTMUL = 4'd5;  // a_m * T_m(x)
	localparam logic [3:0] S_OUTACC = 4'd6;  // z += product
	localparam logic [3:0] S_ROUND  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;

	order_t order_x_q, order_y_q;
	logic [ORD_W-1:0] ox_q, oy_q;
	logic [ORD_W-1:0] m_q, n_q;
	logic [K_W-1:0]   k_q;
	logic             ph_q;
	logic [ADDR_W-1:0] addr_q;
	logic             v_s1, v_s2;
	logic             done_q;

	point_t x_q, y_q;
	point_t prev1_q, prev2_q;
	point_t tx_tab_q [STRIDE];
	point_t ty_tab_q [STRIDE];
	point_t ty_s1;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [AM_W-1:0]   am_q;
	logic signed [AMR_W-1:0]  amr_q;
	logic signed [ZW-1:0]     z_q;
	logic signed [ZR_W-1:0]   zr_q;
	result_t                  result_q;

	logic accept, load_we, eval_go;
	coeff_t rdata;
	point_t x_cl, y_cl, tx_rd, rec_new;
	logic [ORD_W-1:0] ox_cl, oy_cl;
	logic signed [MA_W-1:0] mul_a;
	point_t                 mul_b;
	logic signed [34:0]     rec_sum;
	logic signed [19:0]     rec_diff;
	logic signed [AM_W:0]   am_bias;
	logic signed [ZW:0]     z_bias;
	logic signed [EXT_W-1:0] zr_ext, lim_hi, lim_lo;

	function automatic logic [ORD_W-1:0] clip_order(input order_t o);
		logic [ORD_W-1:0] r;
		if (o == '0) begin
			r = ORD_W'(1);
		end else if (int'(o) > MAX_ORDER) begin
			r = ORD_W'(MAX_ORDER);
		end else begin
			r = ORD_W'(o);
		end
		return r;
	endfunction

	function automatic point_t clamp_pt(input point_t v);
		point_t r;
		if (v > ONE_Q16) begin
			r = ONE_Q16;
		end else if (v < -ONE_Q16) begin
			r = -ONE_Q16;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign accept  = start && !busy;
	assign load_we = accept && (operation == OP_LOAD) && (32'(coeff_index) < DEPTH);
	assign eval_go = accept && (operation == OP_EVAL);
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign series_value = result_q;

	assign x_cl  = clamp_pt(x_point);
	assign y_cl  = clamp_pt(y_point);
	assign ox_cl = clip_order(order_x_q);
	assign oy_cl = clip_order(order_y_q);
	assign tx_rd = tx_tab_q[m_q];

	cheb2d_coeff_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (ADDR_W'(coeff_index)),
		.wdata (coeff_value),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_TX: begin
				mul_a = MA_W'(x_q);
				mul_b = prev1_q;
			end
			S_TY: begin
				mul_a = MA_W'(y_q);
				mul_b = prev1_q;
			end
			S_OUTMUL: begin
				mul_a = amr_q;
				mul_b = tx_rd;
			end
			default: begin
				mul_a = MA_W'(rdata);
				mul_b = ty_s1;
			end
		endcase
	end

	// recurrence: clamp(round(2*t*T(k-1)) - T(k-2)); |t*T| <= 2^32
	always_comb begin
		rec_sum  = $signed({prod_q[33:0], 1'b0}) + 35'sd32768;
		rec_diff = 20'($signed(rec_sum[34:16])) - 20'(prev2_q);
		if (rec_diff > 20'sd65536) begin
			rec_new = ONE_Q16;
		end else if (rec_diff < -20'sd65536) begin
			rec_new = -ONE_Q16;
		end else begin
			rec_new = PT_W'(rec_diff);
		end
	end

	// round half up, then saturate the result
	assign am_bias = (AM_W+1)'(am_q) + (AM_W+1)'(32768);
	assign z_bias  = (ZW+1)'(z_q) + (ZW+1)'(32768);
	assign zr_ext  = EXT_W'(zr_q);
	assign lim_hi  = EXT_W'(OUT_MAX);
	assign lim_lo  = EXT_W'(OUT_MIN);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			order_x_q <= ORDER_RST;
			order_y_q <= ORDER_RST;
			ox_q      <= '0;
			oy_q      <= '0;
			m_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			ph_q      <= 1'b0;
			addr_q    <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= v_s1;
			if (cfg_we) begin
				if (cfg_index == CFG_ORDER_X) begin
					order_x_q <= cfg_data;
				end else begin
					order_y_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (eval_go) begin
						ox_q    <= ox_cl;
						oy_q    <= oy_cl;
						k_q     <= K_W'(2);
						ph_q    <= 1'b0;
						state_q <= S_TX;
					end
				end
				S_TX: begin
					if (!ph_q && (k_q > K_W'(ox_q))) begin
						k_q     <= K_W'(2);
						state_q <= S_TY;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							k_q <= k_q + K_W'(1);
						end
					end
				end
				S_TY: begin
					if (!ph_q && (k_q > K_W'(oy_q))) begin
						m_q     <= '0;
						n_q     <= '0;
						addr_q  <= '0;
						state_q <= S_INNER;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							k_q <= k_q + K_W'(1);
						end
					end
				end
				S_INNER: begin
					v_s1   <= 1'b1;
					addr_q <= addr_q + ADDR_W'(STRIDE);
					n_q    <= n_q + ORD_W'(1);
					if (n_q == oy_q) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_OUTMUL;
					end
				end
				S_OUTMUL: begin
					state_q <= S_OUTACC;
				end
				S_OUTACC: begin
					if (m_q == ox_q) begin
						state_q <= S_ROUND;
					end else begin
						m_q     <= m_q + ORD_W'(1);
						n_q     <= '0;
						addr_q  <= ADDR_W'(m_q) + ADDR_W'(1);
						state_q <= S_INNER;
					end
				end
				S_ROUND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		ty_s1  <= ty_tab_q[n_q];
		if (v_s2) begin
			am_q <= am_q + AM_W'(prod_q);
		end
		case (state_q)
			S_IDLE: begin
				if (eval_go) begin
					x_q         <= x_cl;
					y_q         <= y_cl;
					tx_tab_q[0] <= ONE_Q16;
					tx_tab_q[1] <= x_cl;
					ty_tab_q[0] <= ONE_Q16;
					ty_tab_q[1] <= y_cl;
					prev2_q     <= ONE_Q16;
					prev1_q     <= x_cl;
					z_q         <= '0;
				end
			end
			S_TX: begin
				if (!ph_q && (k_q > K_W'(ox_q))) begin
					prev2_q <= ONE_Q16;
					prev1_q <= y_q;
				end else if (ph_q) begin
					tx_tab_q[k_q[ORD_W-1:0]] <= rec_new;
					prev2_q <= prev1_q;
					prev1_q <= rec_new;
				end
			end
			S_TY: begin
				if (!ph_q && (k_q > K_W'(oy_q))) begin
					am_q <= '0;
				end else if (ph_q) begin
					ty_tab_q[k_q[ORD_W-1:0]] <= rec_new;
					prev2_q <= prev1_q;
					prev1_q <= rec_new;
				end
			end
			S_WAIT: begin
				amr_q <= am_bias[AM_W:16];
			end
			S_OUTACC: begin
				z_q  <= z_q + ZW'(prod_q);
				am_q <= '0;
			end
			S_ROUND: begin
				zr_q <= z_bias[ZW:16];
			end
			S_DONE: begin
				if (zr_ext > lim_hi) begin
					result_q <= OUT_MAX;
				end else if (zr_ext < lim_lo) begin
					result_q <= OUT_MIN;
				end else begin
					result_q <= OUT_W'(zr_q);
				end
			end
			default: begin
			end
		endcase
	end

	// an evaluation ends only with its result strobe
	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// done is never high twice in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// MAC pipe only runs while a column is being summed
	a_pipe_in_column: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_INNER || state_q == S_WAIT))
		else $error("MAC pipe active outside column sum");

	// column walk never passes the y order
	a_column_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INNER) |-> (n_q <= oy_q))
		else $error("column index beyond y order");

endmodule
